@@ src/tron_pkg.sv @@
`default_nettype none

package tron_pkg;

	// Telnet command bytes.
	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO   = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB   = 8'd250;
	localparam logic [7:0] B_SE   = 8'd240;

	// Option codes handled by the negotiator.
	localparam logic [7:0] OPT_BIN   = 8'd0;
	localparam logic [7:0] OPT_ECHO  = 8'd1;
	localparam logic [7:0] OPT_SGA   = 8'd3;
	localparam logic [7:0] OPT_TTYPE = 8'd24;
	localparam logic [7:0] OPT_NAWS  = 8'd31;

	// Terminal-type subnegotiation SEND code, and its IS code.
	localparam logic [7:0] TTYPE_SEND = 8'd1;
	localparam logic [7:0] TTYPE_IS   = 8'd0;

	// Parser states.
	localparam logic [2:0] ST_DATA   = 3'd0;
	localparam logic [2:0] ST_IAC    = 3'd1;
	localparam logic [2:0] ST_CMD    = 3'd2;
	localparam logic [2:0] ST_SB     = 3'd3;
	localparam logic [2:0] ST_SB_IAC = 3'd4;

	// Kinds of work handed from the parser to the reply sequencer.
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_REPLY = 2'd1;
	localparam logic [1:0] KIND_NAWS  = 2'd2;
	localparam logic [1:0] KIND_TTYPE = 2'd3;

	// Output burst lengths in bytes.
	localparam int LEN_DATA  = 1;
	localparam int LEN_REPLY = 3;
	localparam int LEN_NAWS  = 12;
	localparam int LEN_TTYPE = 10;
	localparam int IDX_W     = $clog2(LEN_NAWS);

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_COLUMNS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_ROWS    = 1'd1;

	typedef struct packed {
		logic echo;
		logic binary;
		logic sga;
	} flags_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] cmd;
		logic [7:0] opt;
		flags_t     flags;
	} job_t;

	// A window size of 255 would read as IAC, so it is sent as 254.
	function automatic logic [7:0] clip_size(input logic [7:0] v);
		clip_size = (v == 8'd255) ? 8'd254 : v;
	endfunction

endpackage

`default_nettype wire

@@ src/telnet_rx_option_negotiator.sv @@
// Telnet receive option negotiator.
// Input stream (s_axis): one byte from the remote host per transaction.
// Output stream (m_axis): the bytes that the received byte gives rise to, in order:
// terminal data (tuser low) or negotiation replies for the host (tuser high).
// tlast marks the final output byte of one input byte. The option flags
// travel beside each output byte as they stand after that input byte.
// A plain data byte, or a doubled IAC, passes through the work queue and then
// the output register before it is offered on the output. Option replies are
// bursts of 3, 10 or 12 bytes. The parser takes one byte per cycle while the
// queue has room; the reply sequencer sends one output byte per cycle while the
// receiver is ready, so the output byte rate sets the sustained throughput.
// A queue of QUEUE_DEPTH work items decouples the two; the input stalls only
// while that queue is full. When the receiver deasserts m_axis_tready the
// output byte holds and the queue fills behind it.
// Reset returns the parser to data state with echo set, binary and
// suppress-go-ahead clear, and the window size to 80 columns by 25 rows.
// Window size registers are written through cfg_wr_en, cfg_index and cfg_wdata;
// the user must write them only while the block is idle; the block does not enforce it.
`default_nettype none

module telnet_rx_option_negotiator #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [7:0] out_byte, [8] echo_by_remote, [9] binary_mode, [10] no_go_ahead
	output logic [15:0]                           m_axis_tdata,
	output logic                                  m_axis_tuser,  // [0] to_host
	output logic                                  m_axis_tlast,
	input  wire logic                             cfg_wr_en,
	input  wire logic [tron_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [7:0]                       cfg_wdata
);

	logic [7:0]       window_columns_q;
	logic [7:0]       window_rows_q;
	logic             push;
	tron_pkg::job_t   push_job;
	tron_pkg::job_t   head_job;
	logic             not_empty;
	logic             full;
	logic             pop;
	logic [7:0]       out_byte;
	tron_pkg::flags_t out_flags;

	// Window size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_columns_q <= 8'd80;
			window_rows_q    <= 8'd25;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tron_pkg::REG_WINDOW_COLUMNS: window_columns_q <= cfg_wdata;
				tron_pkg::REG_WINDOW_ROWS:    window_rows_q    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Parser front end.
	tron_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.queue_full (full),
		.push       (push),
		.job        (push_job)
	);

	// Work queue between parser and sequencer.
	tron_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.head_job  (head_job),
		.not_empty (not_empty),
		.full      (full)
	);

	// Reply sequencer and output register.
	tron_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job            (head_job),
		.job_valid      (not_empty),
		.pop            (pop),
		.window_columns (window_columns_q),
		.window_rows    (window_rows_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_byte       (out_byte),
		.out_to_host    (m_axis_tuser),
		.out_last       (m_axis_tlast),
		.out_flags      (out_flags)
	);

	assign m_axis_tdata = {5'b0, out_flags.sga, out_flags.binary, out_flags.echo, out_byte};

endmodule

`default_nettype wire

@@ src/tron_front.sv @@
`default_nettype none

module tron_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   in_byte,
	input  wire logic         queue_full,
	output logic              push,
	output tron_pkg::job_t    job
);

	logic [2:0]       state_q, state_d;
	logic [7:0]       pend_q, pend_d;
	logic [7:0]       subopt_q, subopt_d;
	tron_pkg::flags_t flags_q, flags_d;
	logic             accept;
	logic             emit;
	logic             sb_take;

	assign in_ready = !queue_full;
	assign accept   = in_valid && !queue_full;

	// Parser next state and the work item that this byte produces.
	always_comb begin
		state_d  = state_q;
		pend_d   = pend_q;
		subopt_d = subopt_q;
		flags_d  = flags_q;
		emit     = 1'b0;
		sb_take  = 1'b0;
		job.kind = tron_pkg::KIND_DATA;
		job.cmd  = tron_pkg::B_IAC;
		job.opt  = in_byte;
		case (state_q)
			tron_pkg::ST_DATA: begin
				if (in_byte == tron_pkg::B_IAC) begin
					state_d = tron_pkg::ST_IAC;
				end else begin
					emit = 1'b1;
				end
			end
			tron_pkg::ST_IAC: begin
				if (in_byte == tron_pkg::B_IAC) begin
					// A doubled IAC is a literal 255 for the terminal.
					state_d = tron_pkg::ST_DATA;
					emit    = 1'b1;
				end else if (in_byte == tron_pkg::B_SB) begin
					state_d  = tron_pkg::ST_SB;
					subopt_d = '0;
				end else if (in_byte == tron_pkg::B_WILL || in_byte == tron_pkg::B_WONT ||
						in_byte == tron_pkg::B_DO || in_byte == tron_pkg::B_DONT) begin
					pend_d  = in_byte;
					state_d = tron_pkg::ST_CMD;
				end else begin
					state_d = tron_pkg::ST_DATA;
				end
			end
			tron_pkg::ST_CMD: begin
				state_d  = tron_pkg::ST_DATA;
				job.kind = tron_pkg::KIND_REPLY;
				case (pend_q)
					tron_pkg::B_DO: begin
						emit = 1'b1;
						if (in_byte == tron_pkg::OPT_NAWS) begin
							job.kind = tron_pkg::KIND_NAWS;
						end else if (in_byte == tron_pkg::OPT_TTYPE) begin
							job.cmd = tron_pkg::B_WILL;
						end else if (in_byte == tron_pkg::OPT_BIN) begin
							flags_d.binary = 1'b1;
							job.cmd        = tron_pkg::B_WILL;
						end else begin
							job.cmd = tron_pkg::B_WONT;
						end
					end
					tron_pkg::B_DONT: begin
						emit    = 1'b1;
						job.cmd = tron_pkg::B_WONT;
						if (in_byte == tron_pkg::OPT_ECHO) begin
							flags_d.echo = 1'b0;
						end else if (in_byte == tron_pkg::OPT_BIN) begin
							flags_d.binary = 1'b0;
						end
					end
					tron_pkg::B_WILL: begin
						emit    = 1'b1;
						job.cmd = tron_pkg::B_DO;
						if (in_byte == tron_pkg::OPT_ECHO) begin
							flags_d.echo = 1'b1;
						end else if (in_byte == tron_pkg::OPT_SGA) begin
							flags_d.sga = 1'b1;
						end else if (in_byte == tron_pkg::OPT_BIN) begin
							flags_d.binary = 1'b1;
						end
					end
					tron_pkg::B_WONT: begin
						emit    = 1'b1;
						job.cmd = tron_pkg::B_DONT;
						if (in_byte == tron_pkg::OPT_ECHO) begin
							flags_d.echo = 1'b0;
						end else if (in_byte == tron_pkg::OPT_SGA) begin
							flags_d.sga = 1'b0;
						end else if (in_byte == tron_pkg::OPT_BIN) begin
							flags_d.binary = 1'b0;
						end
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
			tron_pkg::ST_SB: begin
				if (in_byte == tron_pkg::B_IAC) begin
					state_d = tron_pkg::ST_SB_IAC;
				end else begin
					sb_take = 1'b1;
				end
			end
			tron_pkg::ST_SB_IAC: begin
				if (in_byte == tron_pkg::B_SE) begin
					state_d  = tron_pkg::ST_DATA;
					subopt_d = '0;
				end else begin
					// A stray byte other than IAC is taken again as subnegotiation data.
					state_d = tron_pkg::ST_SB;
					sb_take = (in_byte != tron_pkg::B_IAC);
				end
			end
			default: begin
				state_d = tron_pkg::ST_DATA;
			end
		endcase

		// Subnegotiation payload: the first nonzero byte names the option.
		if (sb_take) begin
			if (subopt_q == '0) begin
				subopt_d = in_byte;
			end else if (subopt_q == tron_pkg::OPT_TTYPE && in_byte == tron_pkg::TTYPE_SEND) begin
				emit     = 1'b1;
				job.kind = tron_pkg::KIND_TTYPE;
			end
		end

		job.flags = flags_d;
		push      = accept && emit;
	end

	// Parser registers advance only on an accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tron_pkg::ST_DATA;
			pend_q         <= '0;
			subopt_q       <= '0;
			flags_q.echo   <= 1'b1;
			flags_q.binary <= 1'b0;
			flags_q.sga    <= 1'b0;
		end else if (accept) begin
			state_q  <= state_d;
			pend_q   <= pend_d;
			subopt_q <= subopt_d;
			flags_q  <= flags_d;
		end
	end

endmodule

`default_nettype wire

@@ src/tron_queue.sv @@
`default_nettype none

module tron_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire tron_pkg::job_t   push_job,
	input  wire logic             pop,
	output tron_pkg::job_t        head_job,
	output logic                  not_empty,
	output logic                  full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	tron_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_job  = mem_q[rd_ptr_q];

	// Storage for queued work items.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers wrap at the configured depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/tron_back.sv @@
`default_nettype none

module tron_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tron_pkg::job_t job,
	input  wire logic           job_valid,
	output logic                pop,
	input  wire logic [7:0]     window_columns,
	input  wire logic [7:0]     window_rows,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          out_byte,
	output logic                out_to_host,
	output logic                out_last,
	output tron_pkg::flags_t    out_flags
);

	logic [tron_pkg::IDX_W-1:0] idx_q;
	logic                       valid_q;
	logic [7:0]                 byte_q;
	logic                       host_q;
	logic                       last_q;
	tron_pkg::flags_t           flags_q;
	logic [7:0]                 sel_byte;
	logic                       sel_host;
	logic [tron_pkg::IDX_W-1:0] sel_len;
	logic                       sel_last;
	logic                       advance;
	logic                       load;

	// Byte idx of the burst that the head work item stands for.
	always_comb begin
		sel_byte = tron_pkg::B_IAC;
		sel_host = 1'b1;
		sel_len  = tron_pkg::IDX_W'(tron_pkg::LEN_REPLY);
		case (job.kind)
			tron_pkg::KIND_DATA: begin
				sel_byte = job.opt;
				sel_host = 1'b0;
				sel_len  = tron_pkg::IDX_W'(tron_pkg::LEN_DATA);
			end
			tron_pkg::KIND_REPLY: begin
				case (idx_q)
					4'd0:    sel_byte = tron_pkg::B_IAC;
					4'd1:    sel_byte = job.cmd;
					default: sel_byte = job.opt;
				endcase
			end
			tron_pkg::KIND_NAWS: begin
				sel_len = tron_pkg::IDX_W'(tron_pkg::LEN_NAWS);
				case (idx_q)
					4'd0:    sel_byte = tron_pkg::B_IAC;
					4'd1:    sel_byte = tron_pkg::B_WILL;
					4'd2:    sel_byte = tron_pkg::OPT_NAWS;
					4'd3:    sel_byte = tron_pkg::B_IAC;
					4'd4:    sel_byte = tron_pkg::B_SB;
					4'd5:    sel_byte = tron_pkg::OPT_NAWS;
					4'd6:    sel_byte = 8'd0;
					4'd7:    sel_byte = tron_pkg::clip_size(window_columns);
					4'd8:    sel_byte = 8'd0;
					4'd9:    sel_byte = tron_pkg::clip_size(window_rows);
					4'd10:   sel_byte = tron_pkg::B_IAC;
					default: sel_byte = tron_pkg::B_SE;
				endcase
			end
			default: begin
				sel_len = tron_pkg::IDX_W'(tron_pkg::LEN_TTYPE);
				case (idx_q)
					4'd0:    sel_byte = tron_pkg::B_IAC;
					4'd1:    sel_byte = tron_pkg::B_SB;
					4'd2:    sel_byte = tron_pkg::OPT_TTYPE;
					4'd3:    sel_byte = tron_pkg::TTYPE_IS;
					4'd4:    sel_byte = 8'h41;
					4'd5:    sel_byte = 8'h4E;
					4'd6:    sel_byte = 8'h53;
					4'd7:    sel_byte = 8'h49;
					4'd8:    sel_byte = tron_pkg::B_IAC;
					default: sel_byte = tron_pkg::B_SE;
				endcase
			end
		endcase
		sel_last = (idx_q == sel_len - 1'b1);
	end

	// The output register takes a new byte whenever it is empty or being drained and a work item is waiting.
	assign advance = !valid_q || out_ready;
	assign load    = advance && job_valid;
	assign pop     = load && sel_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (advance) begin
				valid_q <= job_valid;
			end
			if (load) begin
				idx_q <= sel_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= sel_byte;
			host_q  <= sel_host;
			last_q  <= sel_last;
			flags_q <= job.flags;
		end
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign out_to_host = host_q;
	assign out_last    = last_q;
	assign out_flags   = flags_q;

endmodule

`default_nettype wire

@@ verif/telnet_rx_option_negotiator_tb.sv @@
module telnet_rx_option_negotiator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Telnet NOP, used as a command that the parser does not know.
	localparam logic [7:0] CMD_NOP = 8'd241;
	localparam int PHASES = 5;
	localparam int ITEMS_PER_PHASE = 96;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int STALL_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;

	// One output transaction as the checker sees it.
	typedef struct packed {
		logic [7:0] octet;
		logic       host;
		logic       last;
		logic       echo;
		logic       binary;
		logic       sga;
	} reply_t;

	// One directed row: the byte sent and, where typed, the result count (none or one) and the expected result.
	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		logic [1:0] count;
		logic [7:0] octet;
		logic       host;
	} probe_t;

	localparam probe_t DIRECTED [25] = '{
		'{8'd0,                 1'b1, 2'd1, 8'd0,            1'b0},
		'{8'd254,               1'b1, 2'd1, 8'd254,          1'b0},
		'{tron_pkg::B_IAC,      1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::B_IAC,      1'b1, 2'd1, tron_pkg::B_IAC, 1'b0},
		'{tron_pkg::B_IAC,      1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::B_DO,       1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::OPT_NAWS,   1'b0, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::B_IAC,      1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::B_DONT,     1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::OPT_ECHO,   1'b0, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::B_IAC,      1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::B_WILL,     1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::OPT_SGA,    1'b0, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::B_IAC,      1'b1, 2'd0, 8'd0,            1'b0},
		'{CMD_NOP,              1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::B_IAC,      1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::B_SB,       1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::OPT_BIN,    1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::OPT_TTYPE,  1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::B_IAC,      1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::TTYPE_SEND, 1'b0, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::B_IAC,      1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::B_IAC,      1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::B_IAC,      1'b1, 2'd0, 8'd0,            1'b0},
		'{tron_pkg::B_SE,       1'b1, 2'd0, 8'd0,            1'b0}
	};

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;    // [7:0] rx_byte
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [15:0] m_axis_tdata;   // [7:0] out_byte, [8] echo_by_remote, [9] binary_mode,
	                             // [10] no_go_ahead
	logic m_axis_tuser;          // [0] to_host
	logic m_axis_tlast;
	logic cfg_wr_en;
	logic [tron_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [7:0] cfg_wdata;

	// Mirror of the negotiator state.
	logic [2:0] rx_state;
	logic [7:0] waiting_cmd;
	logic [7:0] sb_option;
	logic echo_f, binary_f, sga_f;
	logic [7:0] win_cols, win_rows;
	logic [8:0] step_bytes[$];   // {to_host, byte} produced by one received byte

	reply_t awaited_replies[$];
	logic [7:0] script[$];
	reply_t seen, want;
	logic calm;
	logic hold_off;
	int faults;
	int n_rx, n_results, n_host, n_settings;
	int quiet_cycles;

	telnet_rx_option_negotiator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result bytes are capped at the longest reply burst.
	function automatic void emit(input logic host, input logic [7:0] b);
		if (step_bytes.size() < tron_pkg::LEN_NAWS) begin
			step_bytes.push_back({host, b});
		end
	endfunction

	function automatic void emit_reply(input logic [7:0] c, input logic [7:0] o);
		emit(1'b1, tron_pkg::B_IAC);
		emit(1'b1, c);
		emit(1'b1, o);
	endfunction

	// A size of 255 would look like IAC on the wire, so it goes out as 254.
	function automatic logic [7:0] size_octet(input logic [7:0] v);
		return (v == 8'd255) ? 8'd254 : v;
	endfunction

	// Option negotiation: flag updates and the reply for one command and option.
	function automatic void negotiate(input logic [7:0] c, input logic [7:0] o);
		case (c)
			tron_pkg::B_DO: begin
				if (o == tron_pkg::OPT_NAWS) begin
					emit_reply(tron_pkg::B_WILL, o);
					emit(1'b1, tron_pkg::B_IAC);
					emit(1'b1, tron_pkg::B_SB);
					emit(1'b1, tron_pkg::OPT_NAWS);
					emit(1'b1, 8'd0);
					emit(1'b1, size_octet(win_cols));
					emit(1'b1, 8'd0);
					emit(1'b1, size_octet(win_rows));
					emit(1'b1, tron_pkg::B_IAC);
					emit(1'b1, tron_pkg::B_SE);
				end else if (o == tron_pkg::OPT_TTYPE) begin
					emit_reply(tron_pkg::B_WILL, o);
				end else if (o == tron_pkg::OPT_BIN) begin
					binary_f = 1'b1;
					emit_reply(tron_pkg::B_WILL, o);
				end else begin
					emit_reply(tron_pkg::B_WONT, o);
				end
			end
			tron_pkg::B_DONT: begin
				if (o == tron_pkg::OPT_ECHO) echo_f = 1'b0;
				else if (o == tron_pkg::OPT_BIN) binary_f = 1'b0;
				emit_reply(tron_pkg::B_WONT, o);
			end
			tron_pkg::B_WILL: begin
				if (o == tron_pkg::OPT_ECHO) echo_f = 1'b1;
				else if (o == tron_pkg::OPT_SGA) sga_f = 1'b1;
				else if (o == tron_pkg::OPT_BIN) binary_f = 1'b1;
				emit_reply(tron_pkg::B_DO, o);
			end
			tron_pkg::B_WONT: begin
				if (o == tron_pkg::OPT_ECHO) echo_f = 1'b0;
				else if (o == tron_pkg::OPT_SGA) sga_f = 1'b0;
				else if (o == tron_pkg::OPT_BIN) binary_f = 1'b0;
				emit_reply(tron_pkg::B_DONT, o);
			end
			default: begin
			end
		endcase
	endfunction

	// One byte inside a subnegotiation; a terminal-type SEND is answered with ANSI.
	function automatic void subnegotiate(input logic [7:0] b);
		if (b == tron_pkg::B_IAC) begin
			rx_state = tron_pkg::ST_SB_IAC;
		end else if (sb_option == 8'd0) begin
			sb_option = b;
		end else if (sb_option == tron_pkg::OPT_TTYPE && b == tron_pkg::TTYPE_SEND) begin
			emit(1'b1, tron_pkg::B_IAC);
			emit(1'b1, tron_pkg::B_SB);
			emit(1'b1, tron_pkg::OPT_TTYPE);
			emit(1'b1, tron_pkg::TTYPE_IS);
			emit(1'b1, "A");
			emit(1'b1, "N");
			emit(1'b1, "S");
			emit(1'b1, "I");
			emit(1'b1, tron_pkg::B_IAC);
			emit(1'b1, tron_pkg::B_SE);
		end
	endfunction

	// Advances the parser mirror by one received byte and fills step_bytes.
	function automatic void parse_rx(input logic [7:0] b);
		step_bytes.delete();
		case (rx_state)
			tron_pkg::ST_DATA: begin
				if (b == tron_pkg::B_IAC) rx_state = tron_pkg::ST_IAC;
				else emit(1'b0, b);
			end
			tron_pkg::ST_IAC: begin
				if (b == tron_pkg::B_IAC) begin
					rx_state = tron_pkg::ST_DATA;
					emit(1'b0, tron_pkg::B_IAC);
				end else if (b == tron_pkg::B_SB) begin
					rx_state = tron_pkg::ST_SB;
					sb_option = 8'd0;
				end else if (b == tron_pkg::B_WILL || b == tron_pkg::B_WONT ||
						b == tron_pkg::B_DO || b == tron_pkg::B_DONT) begin
					waiting_cmd = b;
					rx_state = tron_pkg::ST_CMD;
				end else begin
					rx_state = tron_pkg::ST_DATA;
				end
			end
			tron_pkg::ST_CMD: begin
				negotiate(waiting_cmd, b);
				rx_state = tron_pkg::ST_DATA;
			end
			tron_pkg::ST_SB: begin
				subnegotiate(b);
			end
			tron_pkg::ST_SB_IAC: begin
				if (b == tron_pkg::B_SE) begin
					rx_state = tron_pkg::ST_DATA;
					sb_option = 8'd0;
				end else begin
					rx_state = tron_pkg::ST_SB;
					if (b != tron_pkg::B_IAC) subnegotiate(b);
				end
			end
			default: begin
				rx_state = tron_pkg::ST_DATA;
			end
		endcase
	endfunction

	task automatic note_fault(input string what, input reply_t exp_r, input reply_t got_r);
		faults++;
		if (faults <= REPORT_LIMIT) begin
			$display("%s: expected byte %02h host %0d last %0d echo %0d binary %0d sga %0d",
				what, exp_r.octet, exp_r.host, exp_r.last, exp_r.echo, exp_r.binary, exp_r.sga);
			$display("%s:      got byte %02h host %0d last %0d echo %0d binary %0d sga %0d",
				what, got_r.octet, got_r.host, got_r.last, got_r.echo, got_r.binary, got_r.sga);
		end
	endtask

	// Offers one byte, waits for its transaction and records what it should cause.
	// A typed row replaces the prediction with the result written in the table.
	task automatic offer(input logic [7:0] b, input logic typed, input logic [1:0] count,
			input logic [7:0] octet, input logic host);
		reply_t r;
		int k;
		if (!calm && $urandom_range(99) < 6) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		n_rx++;
		parse_rx(b);
		if (typed) begin
			step_bytes.delete();
			if (count == 2'd1) step_bytes.push_back({host, octet});
		end
		for (k = 0; k < step_bytes.size(); k++) begin
			r.host = step_bytes[k][8];
			r.octet = step_bytes[k][7:0];
			r.last = (k == step_bytes.size() - 1);
			r.echo = echo_f;
			r.binary = binary_f;
			r.sga = sga_f;
			awaited_replies.push_back(r);
		end
	endtask

	// Stops offering until every awaited result is out, then lets the block settle,
	// since a byte with no result may still be inside it.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input logic [7:0] cols, input logic [7:0] rows);
		cfg_wr_en <= 1'b1;
		cfg_index <= tron_pkg::REG_WINDOW_COLUMNS;
		cfg_wdata <= cols;
		@(posedge clk);
		cfg_index <= tron_pkg::REG_WINDOW_ROWS;
		cfg_wdata <= rows;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		win_cols = cols;
		win_rows = rows;
		n_settings++;
	endtask

	// Builds one short stretch of received bytes: mostly well-formed telnet
	// sequences with random content, the rest broken sequences and noise.
	task automatic make_sequence();
		logic [7:0] cmds [4];
		logic [7:0] opts [5];
		int pick, k;
		cmds = '{tron_pkg::B_WILL, tron_pkg::B_WONT, tron_pkg::B_DO, tron_pkg::B_DONT};
		opts = '{tron_pkg::OPT_BIN, tron_pkg::OPT_ECHO, tron_pkg::OPT_SGA,
			tron_pkg::OPT_TTYPE, tron_pkg::OPT_NAWS};
		pick = $urandom_range(99);
		if (pick < 30) begin
			repeat ($urandom_range(1, 6)) script.push_back(8'($urandom_range(0, 254)));
		end else if (pick < 38) begin
			script.push_back(tron_pkg::B_IAC);
			script.push_back(tron_pkg::B_IAC);
		end else if (pick < 70) begin
			script.push_back(tron_pkg::B_IAC);
			script.push_back(cmds[$urandom_range(0, 3)]);
			if ($urandom_range(99) < 80) script.push_back(opts[$urandom_range(0, 4)]);
			else script.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 76) begin
			script.push_back(tron_pkg::B_IAC);
			script.push_back(8'($urandom_range(0, 249)));
		end else if (pick < 90) begin
			script.push_back(tron_pkg::B_IAC);
			script.push_back(tron_pkg::B_SB);
			k = $urandom_range(99);
			if (k < 15) script.push_back(tron_pkg::OPT_BIN);
			if (k < 65) script.push_back(tron_pkg::OPT_TTYPE);
			else script.push_back(8'($urandom_range(1, 254)));
			repeat ($urandom_range(0, 4)) begin
				k = $urandom_range(99);
				if (k < 40) begin
					script.push_back(tron_pkg::TTYPE_SEND);
				end else if (k < 55) begin
					script.push_back(tron_pkg::B_IAC);
					script.push_back(tron_pkg::B_IAC);
				end else if (k < 65) begin
					script.push_back(tron_pkg::B_IAC);
					script.push_back(8'($urandom_range(0, 239)));
				end else begin
					script.push_back(8'($urandom_range(0, 254)));
				end
			end
			// Now and then the closing IAC SE is left off.
			if ($urandom_range(99) < 90) begin
				script.push_back(tron_pkg::B_IAC);
				script.push_back(tron_pkg::B_SE);
			end
		end else begin
			repeat ($urandom_range(1, 4)) script.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Receiver: random stalls, none in the calm phase, and one long hold-off on request.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(99) >= 6);
			end
		end
	end

	// Checks each output transaction against the oldest awaited result.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.octet = m_axis_tdata[7:0];
			seen.host = m_axis_tuser;
			seen.last = m_axis_tlast;
			seen.echo = m_axis_tdata[8];
			seen.binary = m_axis_tdata[9];
			seen.sga = m_axis_tdata[10];
			n_results++;
			if (seen.host) n_host++;
			if (awaited_replies.size() == 0) begin
				note_fault("unexpected result", '0, seen);
			end else begin
				want = awaited_replies.pop_front();
				if (seen != want) note_fault("result mismatch", want, seen);
			end
		end
	end

	// Watchdog: ends the run when no transaction happens on either side for too long.
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles, %0d results outstanding",
					STALL_LIMIT, awaited_replies.size());
				$display("telnet_rx_option_negotiator_tb: FAIL");
				$finish;
			end
		end
	end

	// Stimulus: reset, the directed table, then random phases over several window sizes.
	initial begin
		logic [7:0] phase_cols [PHASES];
		logic [7:0] phase_rows [PHASES];
		int phase, sent;
		phase_cols = '{8'd80, 8'd0, 8'd255, 8'd1, 8'($urandom_range(1, 254))};
		phase_rows = '{8'd25, 8'd255, 8'd0, 8'd254, 8'($urandom_range(1, 254))};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		cfg_wr_en = 1'b0;
		cfg_index = tron_pkg::REG_WINDOW_COLUMNS;
		cfg_wdata = 8'd0;
		calm = 1'b0;
		hold_off = 1'b0;
		faults = 0;
		n_rx = 0;
		n_results = 0;
		n_host = 0;
		n_settings = 0;
		rx_state = tron_pkg::ST_DATA;
		waiting_cmd = 8'd0;
		sb_option = 8'd0;
		echo_f = 1'b1;
		binary_f = 1'b0;
		sga_f = 1'b0;
		win_cols = 8'd80;
		win_rows = 8'd25;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			offer(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].count,
				DIRECTED[i].octet, DIRECTED[i].host);
		end

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				drain();
				set_window(phase_cols[phase], phase_rows[phase]);
			end
			calm = (phase == 2);
			if (phase == 3) hold_off = 1'b1;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				make_sequence();
				while (script.size() != 0) begin
					offer(script.pop_front(), 1'b0, 2'd0, 8'd0, 1'b0);
					sent++;
					if (phase == 1 && sent == ITEMS_PER_PHASE / 2) drain();
				end
			end
		end
		drain();

		$display("Sent %0d received bytes over %0d window settings after reset defaults;",
			n_rx, n_settings);
		$display("checked %0d output transactions, %0d of them negotiation replies.",
			n_results, n_host);
		if (faults == 0 && awaited_replies.size() == 0) begin
			$display("telnet_rx_option_negotiator_tb: PASS");
		end else begin
			$display("%0d mismatches, %0d results never arrived", faults,
				awaited_replies.size());
			$display("telnet_rx_option_negotiator_tb: FAIL");
		end
		$finish;
	end

endmodule

@@ telnet_rx_option_negotiator.f @@
src/tron_pkg.sv
src/tron_front.sv
src/tron_queue.sv
src/tron_back.sv
src/telnet_rx_option_negotiator.sv
verif/telnet_rx_option_negotiator_tb.sv
